// File: design/md4_block_compression_macros.svh
// Assertion helpers for the md4 compression RTL.
`ifndef MD4_BLOCK_COMPRESSION_MACROS_SVH
`define MD4_BLOCK_COMPRESSION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MD4BC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("md4bc check failed");

// Next-cycle implication, checked outside reset.
`define MD4BC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("md4bc check failed");

`endif

// File: design/md4bc_pkg.sv
package md4bc_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned NUM_STEPS = 48;
   localparam int unsigned PC_W      = 6;
   localparam int unsigned BLK_WORDS = 16;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned ROT_W     = 5;

   localparam logic [WORD_W-1:0] K_ROUND2 = 32'h5A82_7999;
   localparam logic [WORD_W-1:0] K_ROUND3 = 32'h6ED9_EBA1;

   localparam logic [WORD_W-1:0] RST_INIT_A = 32'h6745_2301;
   localparam logic [WORD_W-1:0] RST_INIT_B = 32'hEFCD_AB89;
   localparam logic [WORD_W-1:0] RST_INIT_C = 32'h98BA_DCFE;
   localparam logic [WORD_W-1:0] RST_INIT_D = 32'h1032_5476;

   // Configuration register indexes.
   localparam logic [1:0] CSR_INIT_A = 2'd0;
   localparam logic [1:0] CSR_INIT_B = 2'd1;
   localparam logic [1:0] CSR_INIT_C = 2'd2;
   localparam logic [1:0] CSR_INIT_D = 2'd3;

   typedef enum logic [1:0] {
      OP_F   = 2'd0,
      OP_G   = 2'd1,
      OP_H   = 2'd2,
      OP_FIN = 2'd3
   } md4bc_op_type;

   // One microcode word.
   typedef struct packed {
      md4bc_op_type     op;
      logic [1:0]       tgt;
      logic [POS_W-1:0] msg;
      logic [ROT_W-1:0] rot;
   } md4bc_uop_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic             load;
      logic             step;
      md4bc_op_type     op;
      logic [1:0]       tgt;
      logic [ROT_W-1:0] rot;
   } md4bc_ctrl_type;

   localparam logic [POS_W-1:0] MSG_ORDER [NUM_STEPS] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
      4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
      4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
      4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
      4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
   };

   localparam logic [ROT_W-1:0] SHIFT_AMT [12] = '{
      5'd3, 5'd7, 5'd11, 5'd19,
      5'd3, 5'd5, 5'd9,  5'd13,
      5'd3, 5'd9, 5'd11, 5'd15
   };

   // Microcode store: steps 0..47 run the rounds, anything past is the finish step.
   function automatic md4bc_uop_type md4bc_ucode(input logic [PC_W-1:0] pc);
      md4bc_uop_type u;
      u.op  = OP_FIN;
      u.tgt = 2'd0;
      u.msg = '0;
      u.rot = '0;
      if (pc < PC_W'(NUM_STEPS)) begin
         unique case (pc[5:4])
            2'd0:    u.op = OP_F;
            2'd1:    u.op = OP_G;
            default: u.op = OP_H;
         endcase
         // target cycles A, D, C, B
         u.tgt = 2'(2'd0 - pc[1:0]);
         u.msg = MSG_ORDER[pc];
         u.rot = SHIFT_AMT[{pc[5:4], pc[1:0]}];
      end
      return u;
   endfunction

endpackage

// File: design/md4_block_compression.sv
// MD4 block compression engine.
// req channel: one 32-bit message word per transfer, already little-endian;
// tuser marks the first word of a message, which reloads the chaining words
// from the init_a..init_d registers and restarts the block at word 0.
// rsp channel: one 128-bit word after every sixteenth input word, holding the
// updated chaining words A..D.
// csr channel: register index and data, always ready; write only while idle.
// Timing: words are taken one per cycle until the sixteenth. That word starts
// a microcoded run of 48 round steps, one step per cycle through a single
// adder/rotate datapath, then one finish step that adds into the chaining
// words and loads the output register. req_tready is low from the sixteenth
// word until the finish step has completed.
// If the receiver stalls, the finish step waits until the output register
// frees up; a new block can still be collected while a result is pending.
// Reset restores the init registers and chaining words to the standard MD4
// start values and clears the word position.
module md4_block_compression (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [md4bc_pkg::WORD_W-1:0]     req_tdata,   // message_word
   input  logic                             req_tuser,   // start_message
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [4*md4bc_pkg::WORD_W-1:0]   rsp_tdata,   // hash_a, hash_b, hash_c, hash_d
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [md4bc_pkg::WORD_W-1:0]     csr_data
);
   import md4bc_pkg::*;

   `include "md4_block_compression_macros.svh"

   logic [3:0][WORD_W-1:0]     init_ff, init_in;
   logic [3:0][WORD_W-1:0]     chain_ff, chain_in;
   logic [WORD_W-1:0]          blk_ff [BLK_WORDS];
   logic [POS_W-1:0]           pos_ff, pos_in, pos_wr;
   logic                       busy_ff, busy_in;
   logic [PC_W-1:0]            pc_ff, pc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [4*WORD_W-1:0]        rsp_data_ff;
   logic [3:0][WORD_W-1:0]     sums;
   logic [3:0][WORD_W-1:0]     work;
   md4bc_uop_type              uop;
   md4bc_ctrl_type             ctrl;
   logic                       req_fire, last_word, fin_fire;

   assign req_tready = !busy_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_fire  = req_tvalid && req_tready;
   assign pos_wr    = req_tuser ? '0 : pos_ff;
   assign last_word = (pos_wr == POS_W'(BLK_WORDS - 1));

   assign uop      = md4bc_ucode(pc_ff);
   assign fin_fire = busy_ff && (uop.op == OP_FIN) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctrl.load = req_fire && last_word;
      ctrl.step = busy_ff && (uop.op != OP_FIN);
      ctrl.op   = uop.op;
      ctrl.tgt  = uop.tgt;
      ctrl.rot  = uop.rot;
   end

   md4bc_core u_core (
      .clock    (clock),
      .ctrl     (ctrl),
      .chain    (chain_ff),
      .msg_word (blk_ff[uop.msg]),
      .work     (work)
   );

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sums[i] = chain_ff[i] + work[i];
      end
   end

   always_comb begin
      init_in = init_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INIT_A: init_in[0] = csr_data;
            CSR_INIT_B: init_in[1] = csr_data;
            CSR_INIT_C: init_in[2] = csr_data;
            CSR_INIT_D: init_in[3] = csr_data;
            default:    init_in = init_ff;
         endcase
      end
   end

   always_comb begin
      chain_in     = chain_ff;
      pos_in       = pos_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         if (req_tuser) begin
            chain_in = init_ff;
         end
         pos_in = pos_wr + POS_W'(1);
         if (last_word) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end
      if (busy_ff) begin
         if (uop.op != OP_FIN) begin
            pc_in = pc_ff + PC_W'(1);
         end else if (fin_fire) begin
            // finish step: fold into chaining words and return to idle
            chain_in     = sums;
            rsp_valid_in = 1'b1;
            busy_in      = 1'b0;
            pc_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= {RST_INIT_D, RST_INIT_C, RST_INIT_B, RST_INIT_A};
         chain_ff     <= {RST_INIT_D, RST_INIT_C, RST_INIT_B, RST_INIT_A};
         pos_ff       <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         chain_ff     <= chain_in;
         pos_ff       <= pos_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         blk_ff[pos_wr] <= req_tdata;
      end
      if (fin_fire) begin
         rsp_data_ff <= sums;
      end
   end

   `MD4BC_ASSERT_NEXT(a_block_starts_run, req_fire && last_word, busy_ff && pc_ff == '0)
   `MD4BC_ASSERT_NEXT(a_pc_advances, busy_ff && uop.op != OP_FIN,
      busy_ff && pc_ff == $past(pc_ff) + PC_W'(1))
   `MD4BC_ASSERT_NEXT(a_finish_emits, fin_fire, !busy_ff && rsp_tvalid)
   `MD4BC_ASSERT_NOW(a_pc_in_range, busy_ff, pc_ff <= PC_W'(NUM_STEPS))

endmodule

// File: design/md4bc_core.sv
module md4bc_core (
   input  logic                                   clock,
   input  md4bc_pkg::md4bc_ctrl_type              ctrl,
   input  logic [3:0][md4bc_pkg::WORD_W-1:0]      chain,
   input  logic [md4bc_pkg::WORD_W-1:0]           msg_word,
   output logic [3:0][md4bc_pkg::WORD_W-1:0]      work
);
   import md4bc_pkg::*;

   logic [3:0][WORD_W-1:0] w_ff;
   logic [3:0][WORD_W-1:0] w_in;
   logic [WORD_W-1:0]      x, y, z, f, sum;
   logic [2*WORD_W-1:0]    dbl;

   always_comb begin
      x = w_ff[2'(ctrl.tgt + 2'd1)];
      y = w_ff[2'(ctrl.tgt + 2'd2)];
      z = w_ff[2'(ctrl.tgt + 2'd3)];
      unique case (ctrl.op)
         OP_F:    f = (x & y) | (~x & z);
         OP_G:    f = ((x & y) | (x & z) | (y & z)) + K_ROUND2;
         OP_H:    f = (x ^ y ^ z) + K_ROUND3;
         default: f = '0;
      endcase
      sum = w_ff[ctrl.tgt] + f + msg_word;
      dbl = {sum, sum} << ctrl.rot;
   end

   always_comb begin
      w_in = w_ff;
      if (ctrl.load) begin
         w_in = chain;
      end else if (ctrl.step) begin
         w_in[ctrl.tgt] = dbl[2*WORD_W-1:WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign work = w_ff;

endmodule
